@@ rtl/rectifier_sector_duty_modulator_core_defines.svh @@
// ---------------------------------------------------------------------------
// Rectifier sector duty modulator: assertion macros
// Clocked assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef RECTIFIER_SECTOR_DUTY_MODULATOR_CORE_DEFINES_SVH
`define RECTIFIER_SECTOR_DUTY_MODULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RSDM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define RSDM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RSDM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSDM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/rsdm_pkg.sv @@
// ---------------------------------------------------------------------------
// rsdm_pkg
// Widths, sector codes and pipeline item types of the sector duty modulator.
// ---------------------------------------------------------------------------
`default_nettype none

package rsdm_pkg;

  // field widths
  localparam int VOLTAGE_BITS = 16;
  localparam int PERIOD_W     = 16;
  localparam int DUTY_W       = PERIOD_W;
  localparam int CMP_W        = 16;
  localparam int NUM_CMP      = 6;
  localparam int SECTOR_W     = 3;
  localparam int MASK_W       = 6;

  // internal arithmetic: c = -a-b needs two extra bits, its magnitude one
  localparam int SUM_W  = VOLTAGE_BITS + 2;
  localparam int MAG_W  = VOLTAGE_BITS + 1;
  localparam int PROD_W = MAG_W + PERIOD_W;

  // stream packing
  localparam int IN_FIELD_W   = 2 * VOLTAGE_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W  = SECTOR_W + DUTY_W + NUM_CMP * CMP_W + MASK_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [0:0] REG_PERIOD_IDX = 1'b0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(7500);

  // compare slot order A1, B1, A2, B2, A3, B3
  localparam int SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A3 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_B3 = 3'd5;

  typedef enum logic [SECTOR_W-1:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_e;

  // after sector decode
  typedef struct packed {
    sector_e            sector;
    logic [MAG_W-1:0]   num;
    logic [MAG_W-1:0]   den;
  } front_item_t;

  // travels down the divider chain
  typedef struct packed {
    sector_e             sector;
    logic                den_zero;
    logic                sat;
    logic [PROD_W-1:0]   dd;
    logic [PROD_W-1:0]   rem;
    logic [DUTY_W-1:0]   quot;
  } div_item_t;

endpackage

`default_nettype wire

@@ rtl/rsdm_front.sv @@
// ---------------------------------------------------------------------------
// rsdm_front
// Derives phase c, picks the sector and the numerator/denominator magnitudes.
// ---------------------------------------------------------------------------
`default_nettype none

module rsdm_front (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  output logic                                           ready_o,
  input  wire logic signed [rsdm_pkg::VOLTAGE_BITS-1:0]  a_i,
  input  wire logic signed [rsdm_pkg::VOLTAGE_BITS-1:0]  b_i,
  output logic                                           valid_o,
  input  wire logic                                      ready_i,
  output rsdm_pkg::front_item_t                          item_o
);

  function automatic logic [rsdm_pkg::MAG_W-1:0] mag_of(
    input logic signed [rsdm_pkg::SUM_W-1:0] x
  );
    logic signed [rsdm_pkg::SUM_W-1:0] n;
    n = x[rsdm_pkg::SUM_W-1] ? -x : x;
    return n[rsdm_pkg::MAG_W-1:0];
  endfunction

  logic signed [rsdm_pkg::SUM_W-1:0] a_ext, b_ext, c_ext;
  logic [rsdm_pkg::MAG_W-1:0]        a_mag, b_mag, c_mag;
  logic                              sa, sb, sc;
  rsdm_pkg::front_item_t             item_d, item_q;
  logic                              valid_q;
  logic                              load;

  // phase c and sign flags (1 when >= 0)
  always_comb begin
    a_ext = rsdm_pkg::SUM_W'(a_i);
    b_ext = rsdm_pkg::SUM_W'(b_i);
    c_ext = -a_ext - b_ext;
    sa    = ~a_ext[rsdm_pkg::SUM_W-1];
    sb    = ~b_ext[rsdm_pkg::SUM_W-1];
    sc    = ~c_ext[rsdm_pkg::SUM_W-1];
    a_mag = mag_of(a_ext);
    b_mag = mag_of(b_ext);
    c_mag = mag_of(c_ext);
  end

  // sector decode and ratio selection
  always_comb begin
    if (sa && !sb && !sc)       item_d.sector = rsdm_pkg::SECTOR_1;
    else if (sa && sb && !sc)   item_d.sector = rsdm_pkg::SECTOR_2;
    else if (!sa && sb && !sc)  item_d.sector = rsdm_pkg::SECTOR_3;
    else if (!sa && sb && sc)   item_d.sector = rsdm_pkg::SECTOR_4;
    else if (!sa && !sb && sc)  item_d.sector = rsdm_pkg::SECTOR_5;
    else                        item_d.sector = rsdm_pkg::SECTOR_6;

    case (item_d.sector)
      rsdm_pkg::SECTOR_1: begin
        item_d.num = b_mag;
        item_d.den = a_mag;
      end
      rsdm_pkg::SECTOR_2: begin
        item_d.num = b_mag;
        item_d.den = c_mag;
      end
      rsdm_pkg::SECTOR_3: begin
        item_d.num = c_mag;
        item_d.den = b_mag;
      end
      rsdm_pkg::SECTOR_4: begin
        item_d.num = c_mag;
        item_d.den = a_mag;
      end
      rsdm_pkg::SECTOR_5: begin
        item_d.num = a_mag;
        item_d.den = c_mag;
      end
      default: begin
        item_d.num = a_mag;
        item_d.den = b_mag;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/rsdm_mul.sv @@
// ---------------------------------------------------------------------------
// rsdm_mul
// Scales the numerator by the period and aligns the divisor for the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module rsdm_mul (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [rsdm_pkg::PERIOD_W-1:0]    period_i,
  input  wire logic                             valid_i,
  output logic                                  ready_o,
  input  wire rsdm_pkg::front_item_t            item_i,
  output logic                                  valid_o,
  input  wire logic                             ready_i,
  output rsdm_pkg::div_item_t                   item_o
);

  rsdm_pkg::div_item_t item_d, item_q;
  logic                valid_q;
  logic                load;

  // num >= den means the quotient reaches the period: saturate
  always_comb begin
    item_d.sector   = item_i.sector;
    item_d.den_zero = (item_i.den == '0);
    item_d.sat      = (item_i.num >= item_i.den);
    item_d.dd       = {item_i.den, {rsdm_pkg::PERIOD_W{1'b0}}};
    item_d.rem      = rsdm_pkg::PROD_W'(item_i.num) * rsdm_pkg::PROD_W'(period_i);
    item_d.quot     = '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/rsdm_div_cell.sv @@
// ---------------------------------------------------------------------------
// rsdm_div_cell
// One restoring division step: doubles the remainder, yields one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module rsdm_div_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire rsdm_pkg::div_item_t    item_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output rsdm_pkg::div_item_t         item_o
);

  rsdm_pkg::div_item_t           item_d, item_q;
  logic [rsdm_pkg::PROD_W-1:0]   dbl;
  logic                          bit_set;
  logic                          valid_q;
  logic                          load;

  // remainder stays below dd, so doubling it never overflows
  always_comb begin
    item_d      = item_i;
    dbl         = {item_i.rem[rsdm_pkg::PROD_W-2:0], 1'b0};
    bit_set     = (dbl >= item_i.dd);
    item_d.rem  = bit_set ? (dbl - item_i.dd) : dbl;
    item_d.quot = {item_i.quot[rsdm_pkg::DUTY_W-2:0], bit_set};
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/rsdm_back.sv @@
// ---------------------------------------------------------------------------
// rsdm_back
// Final duty, compare routing and force-set mask; holds the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rsdm_back (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [rsdm_pkg::PERIOD_W-1:0]         period_i,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire rsdm_pkg::div_item_t                   item_i,
  output logic                                       valid_o,
  input  wire logic                                  ready_i,
  output logic [rsdm_pkg::OUT_TDATA_W-1:0]           tdata_o
);

  // force-set pairs
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_1A2B = 6'h09;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_2A3B = 6'h24;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_1B3A = 6'h12;

  localparam int PAD_W = rsdm_pkg::OUT_TDATA_W - rsdm_pkg::OUT_FIELD_W;

  logic [rsdm_pkg::DUTY_W-1:0]    duty;
  logic [rsdm_pkg::CMP_W-1:0]     comp, dflt;
  logic [rsdm_pkg::CMP_W-1:0]     cmp [rsdm_pkg::NUM_CMP];
  logic [rsdm_pkg::SLOT_W-1:0]    duty_slot, comp_slot;
  logic [rsdm_pkg::MASK_W-1:0]    mask;
  logic [rsdm_pkg::OUT_TDATA_W-1:0] tdata_d, tdata_q;
  logic                           valid_q;
  logic                           load;

  // duty: zero divisor wins, then saturation at the period
  always_comb begin
    if (item_i.den_zero)   duty = '0;
    else if (item_i.sat)   duty = period_i;
    else                   duty = item_i.quot;
    comp = period_i - duty + rsdm_pkg::CMP_W'(1);
    dflt = period_i + rsdm_pkg::CMP_W'(1);
  end

  // per-sector routing
  always_comb begin
    case (item_i.sector)
      rsdm_pkg::SECTOR_1: begin
        duty_slot = rsdm_pkg::SLOT_B2;
        comp_slot = rsdm_pkg::SLOT_B3;
        mask      = MASK_1A2B;
      end
      rsdm_pkg::SECTOR_2: begin
        duty_slot = rsdm_pkg::SLOT_A2;
        comp_slot = rsdm_pkg::SLOT_A1;
        mask      = MASK_2A3B;
      end
      rsdm_pkg::SECTOR_3: begin
        duty_slot = rsdm_pkg::SLOT_B3;
        comp_slot = rsdm_pkg::SLOT_B1;
        mask      = MASK_2A3B;
      end
      rsdm_pkg::SECTOR_4: begin
        duty_slot = rsdm_pkg::SLOT_A3;
        comp_slot = rsdm_pkg::SLOT_A2;
        mask      = MASK_1B3A;
      end
      rsdm_pkg::SECTOR_5: begin
        duty_slot = rsdm_pkg::SLOT_B1;
        comp_slot = rsdm_pkg::SLOT_B2;
        mask      = MASK_1B3A;
      end
      default: begin
        duty_slot = rsdm_pkg::SLOT_A1;
        comp_slot = rsdm_pkg::SLOT_A3;
        mask      = MASK_1A2B;
      end
    endcase

    for (int i = 0; i < rsdm_pkg::NUM_CMP; i++) begin
      cmp[i] = dflt;
    end
    cmp[duty_slot] = duty;
    cmp[comp_slot] = comp;

    tdata_d = {{PAD_W{1'b0}}, mask,
               cmp[rsdm_pkg::SLOT_B3], cmp[rsdm_pkg::SLOT_A3], cmp[rsdm_pkg::SLOT_B2],
               cmp[rsdm_pkg::SLOT_A2], cmp[rsdm_pkg::SLOT_B1], cmp[rsdm_pkg::SLOT_A1],
               duty, item_i.sector};
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= tdata_d;
    end
  end

  assign valid_o = valid_q;
  assign tdata_o = tdata_q;

endmodule

`default_nettype wire

@@ rtl/rectifier_sector_duty_modulator_core.sv @@
// ---------------------------------------------------------------------------
// rectifier_sector_duty_modulator_core
// Sector selection and duty/compare generation for a current-source rectifier
// modulator. Each request of two phase voltages yields one result. The stages are
// sector decode, period multiply, a chain of 16 division cells (one quotient bit
// each) and the output register. A new request is taken every clock unless the
// output stalls; each stage has its own valid bit and hand-off, so a stalled
// result holds only the stages behind it that are full. The period register is
// read live by the multiply and output stages and must only change while idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rectifier_sector_duty_modulator_core_defines.svh"

module rectifier_sector_duty_modulator_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rsdm_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [rsdm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rsdm_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [15:0] phase_a_voltage, [31:16] phase_b_voltage
  input  wire logic [rsdm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [2:0] sector, [18:3] duty_ticks, [34:19] cmp_a1, [50:35] cmp_b1,
  // [66:51] cmp_a2, [82:67] cmp_b2, [98:83] cmp_a3, [114:99] cmp_b3,
  // [120:115] force_set_mask, [127:121] zero
  output logic [rsdm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  localparam int VB = rsdm_pkg::VOLTAGE_BITS;
  localparam int NCELL = rsdm_pkg::PERIOD_W;

  logic [rsdm_pkg::PERIOD_W-1:0] period_q;
  logic                          reg_hit;
  logic                          reg_wr;

  logic                          fr_valid, fr_ready;
  rsdm_pkg::front_item_t         fr_item;

  logic                          cell_valid [NCELL+1];
  logic                          cell_ready [NCELL+1];
  rsdm_pkg::div_item_t           cell_item  [NCELL+1];

  // register port: single period register
  assign reg_hit = (paddr[rsdm_pkg::PADDR_W-1:2] == rsdm_pkg::REG_PERIOD_IDX);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? rsdm_pkg::APB_DATA_W'(period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rsdm_pkg::PERIOD_RESET;
    end else if (reg_wr && reg_hit) begin
      period_q <= pwdata[rsdm_pkg::PERIOD_W-1:0];
    end
  end

  // sector decode
  rsdm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .a_i     (s_axis_tdata[VB-1:0]),
    .b_i     (s_axis_tdata[2*VB-1:VB]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .item_o  (fr_item)
  );

  // period scaling
  rsdm_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .valid_i  (fr_valid),
    .ready_o  (fr_ready),
    .item_i   (fr_item),
    .valid_o  (cell_valid[0]),
    .ready_i  (cell_ready[0]),
    .item_o   (cell_item[0])
  );

  // division chain, most significant quotient bit first
  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    rsdm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[gi]),
      .ready_o (cell_ready[gi]),
      .item_i  (cell_item[gi]),
      .valid_o (cell_valid[gi+1]),
      .ready_i (cell_ready[gi+1]),
      .item_o  (cell_item[gi+1])
    );
  end

  // routing and output register
  rsdm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .valid_i  (cell_valid[NCELL]),
    .ready_o  (cell_ready[NCELL]),
    .item_i   (cell_item[NCELL]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .tdata_o  (m_axis_tdata)
  );

  // checks on the result
  `RSDM_ASSERT(a_sector_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[2:0] >= 3'd1 && m_axis_tdata[2:0] <= 3'd6), "sector out of range")
  `RSDM_ASSERT(a_mask_pair, clk_i, rst_ni, m_axis_tvalid |-> ($countones(m_axis_tdata[120:115]) == 2), "force-set mask is not a pair")
  `RSDM_ASSERT_NEVER(a_duty_sat, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[18:3] > period_q), "duty above period")

endmodule

`default_nettype wire

@@ verif/tb_rectifier_sector_duty_modulator_core.sv @@
// ---------------------------------------------------------------------------
// tb_rectifier_sector_duty_modulator_core
// Self-checking bench for the sector duty modulator. Phase voltage requests
// are streamed in and every result is checked field by field against a local
// model of sector decode, duty division and compare mapping. The period is
// reprogrammed between phases, extremes included, while the pipe is drained.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rectifier_sector_duty_modulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  // forced-set mask bits
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_1A = 6'h01;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_1B = 6'h02;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_2A = 6'h04;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_2B = 6'h08;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_3A = 6'h10;
  localparam logic [rsdm_pkg::MASK_W-1:0] MASK_3B = 6'h20;

  // register map
  localparam logic [rsdm_pkg::PADDR_W-1:0] ADDR_PERIOD =
    rsdm_pkg::PADDR_W'(rsdm_pkg::REG_PERIOD_IDX) << 2;
  localparam logic [rsdm_pkg::PADDR_W-1:0] ADDR_NO_REG = rsdm_pkg::PADDR_W'(4);

  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 185;

  // result layout, highest field first
  typedef struct packed {
    logic [rsdm_pkg::OUT_TDATA_W-rsdm_pkg::OUT_FIELD_W-1:0] pad;
    logic [rsdm_pkg::MASK_W-1:0]                            mask;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_b3;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_a3;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_b2;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_a2;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_b1;
    logic [rsdm_pkg::CMP_W-1:0]                             cmp_a1;
    logic [rsdm_pkg::DUTY_W-1:0]                            duty;
    logic [rsdm_pkg::SECTOR_W-1:0]                          sector;
  } modulation_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [rsdm_pkg::PADDR_W-1:0]     paddr = '0;
  logic [rsdm_pkg::APB_DATA_W-1:0]  pwdata = '0;
  logic [rsdm_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rsdm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rsdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [rsdm_pkg::IN_TDATA_W-1:0] pending_samples[$];
  modulation_t                     expected_results[$];
  logic [rsdm_pkg::PERIOD_W-1:0]   period_shadow = rsdm_pkg::PERIOD_RESET;
  int                              err_cnt = 0;
  int                              idle_cycles = 0;
  int                              send_gap = 0;
  int                              recv_stall = 0;
  bit                              send_idle = 1'b1;
  bit                              recv_idle = 1'b1;

  rectifier_sector_duty_modulator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sector, duty and compare values for one pair of phase voltages
  function automatic modulation_t predict_modulation(
    input logic [rsdm_pkg::IN_TDATA_W-1:0] sample,
    input logic [rsdm_pkg::PERIOD_W-1:0]   per
  );
    logic signed [rsdm_pkg::SUM_W-1:0]                      va, vb, vc;
    logic [rsdm_pkg::MAG_W-1:0]                             ma, mb, mc, num, den;
    logic [63:0]                                            quot;
    logic [rsdm_pkg::DUTY_W-1:0]                            duty;
    logic [rsdm_pkg::NUM_CMP-1:0][rsdm_pkg::CMP_W-1:0]      cmp;
    logic [rsdm_pkg::MASK_W-1:0]                            mask;
    logic                                                   sa, sb, sc;
    logic [rsdm_pkg::SLOT_W-1:0]                            duty_slot, comp_slot;
    rsdm_pkg::sector_e                                      sec;
    modulation_t                                            r;
    va = $signed(sample[rsdm_pkg::VOLTAGE_BITS-1:0]);
    vb = $signed(sample[2*rsdm_pkg::VOLTAGE_BITS-1:rsdm_pkg::VOLTAGE_BITS]);
    vc = -va - vb;
    sa = !va[rsdm_pkg::SUM_W-1];
    sb = !vb[rsdm_pkg::SUM_W-1];
    sc = !vc[rsdm_pkg::SUM_W-1];
    ma = sa ? rsdm_pkg::MAG_W'(va) : rsdm_pkg::MAG_W'(-va);
    mb = sb ? rsdm_pkg::MAG_W'(vb) : rsdm_pkg::MAG_W'(-vb);
    mc = sc ? rsdm_pkg::MAG_W'(vc) : rsdm_pkg::MAG_W'(-vc);

    if (sa && !sb && !sc)       sec = rsdm_pkg::SECTOR_1;
    else if (sa && sb && !sc)   sec = rsdm_pkg::SECTOR_2;
    else if (!sa && sb && !sc)  sec = rsdm_pkg::SECTOR_3;
    else if (!sa && sb && sc)   sec = rsdm_pkg::SECTOR_4;
    else if (!sa && !sb && sc)  sec = rsdm_pkg::SECTOR_5;
    else                        sec = rsdm_pkg::SECTOR_6;

    case (sec)
      rsdm_pkg::SECTOR_1: begin
        num = mb; den = ma; mask = MASK_1A | MASK_2B;
        duty_slot = rsdm_pkg::SLOT_B2; comp_slot = rsdm_pkg::SLOT_B3;
      end
      rsdm_pkg::SECTOR_2: begin
        num = mb; den = mc; mask = MASK_2A | MASK_3B;
        duty_slot = rsdm_pkg::SLOT_A2; comp_slot = rsdm_pkg::SLOT_A1;
      end
      rsdm_pkg::SECTOR_3: begin
        num = mc; den = mb; mask = MASK_2A | MASK_3B;
        duty_slot = rsdm_pkg::SLOT_B3; comp_slot = rsdm_pkg::SLOT_B1;
      end
      rsdm_pkg::SECTOR_4: begin
        num = mc; den = ma; mask = MASK_1B | MASK_3A;
        duty_slot = rsdm_pkg::SLOT_A3; comp_slot = rsdm_pkg::SLOT_A2;
      end
      rsdm_pkg::SECTOR_5: begin
        num = ma; den = mc; mask = MASK_1B | MASK_3A;
        duty_slot = rsdm_pkg::SLOT_B1; comp_slot = rsdm_pkg::SLOT_B2;
      end
      default: begin
        num = ma; den = mb; mask = MASK_1A | MASK_2B;
        duty_slot = rsdm_pkg::SLOT_A1; comp_slot = rsdm_pkg::SLOT_A3;
      end
    endcase

    // zero divisor gives no duty, otherwise floor and clip at the period
    if (den == '0) begin
      duty = '0;
    end else begin
      quot = (64'(num) * 64'(per)) / 64'(den);
      duty = (quot > 64'(per)) ? per : rsdm_pkg::DUTY_W'(quot);
    end

    cmp = {rsdm_pkg::NUM_CMP{rsdm_pkg::CMP_W'(per + 1'b1)}};
    cmp[duty_slot] = rsdm_pkg::CMP_W'(duty);
    cmp[comp_slot] = rsdm_pkg::CMP_W'(per - duty + 1'b1);

    r        = '0;
    r.sector = sec;
    r.duty   = duty;
    r.cmp_a1 = cmp[rsdm_pkg::SLOT_A1];
    r.cmp_b1 = cmp[rsdm_pkg::SLOT_B1];
    r.cmp_a2 = cmp[rsdm_pkg::SLOT_A2];
    r.cmp_b2 = cmp[rsdm_pkg::SLOT_B2];
    r.cmp_a3 = cmp[rsdm_pkg::SLOT_A3];
    r.cmp_b3 = cmp[rsdm_pkg::SLOT_B3];
    r.mask   = mask;
    return r;
  endfunction

  // random voltage pair, biased towards sector borders and extremes
  function automatic logic [rsdm_pkg::IN_TDATA_W-1:0] random_sample();
    logic [rsdm_pkg::VOLTAGE_BITS-1:0] v[2];
    int k;
    for (k = 0; k < 2; k++) begin
      case ($urandom_range(0, 5))
        0, 1: v[k] = rsdm_pkg::VOLTAGE_BITS'($urandom);
        2:    v[k] = rsdm_pkg::VOLTAGE_BITS'($urandom_range(0, 16) - 8);
        3:    v[k] = '0;
        4: begin
          case ($urandom_range(0, 3))
            0: v[k] = 16'h8000;
            1: v[k] = 16'h7fff;
            2: v[k] = 16'h8001;
            default: v[k] = 16'hffff;
          endcase
        end
        default: v[k] = rsdm_pkg::VOLTAGE_BITS'($urandom_range(0, 2000) - 1000);
      endcase
    end
    // sometimes make b track -a so that c sits near zero
    if ($urandom_range(0, 7) == 0) begin
      v[1] = -v[0] + rsdm_pkg::VOLTAGE_BITS'($urandom_range(0, 2) - 1);
    end
    return {v[1], v[0]};
  endfunction

  task automatic push_sample(input int a, input int b);
    pending_samples.push_back({rsdm_pkg::VOLTAGE_BITS'(b), rsdm_pkg::VOLTAGE_BITS'(a)});
  endtask

  // one APB transfer; reads of the period are checked against the shadow copy
  task automatic reg_access(input bit wr, input logic [rsdm_pkg::PADDR_W-1:0] addr,
                            input logic [rsdm_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr && addr == ADDR_PERIOD) period_shadow = data[rsdm_pkg::PERIOD_W-1:0];
    if (!wr && addr == ADDR_PERIOD &&
        prdata[rsdm_pkg::PERIOD_W-1:0] !== period_shadow) begin
      $display("%0t: period read mismatch, expected %0d, actual %0d",
               $time, period_shadow, prdata[rsdm_pkg::PERIOD_W-1:0]);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold off until every request has been taken and answered
  task automatic drain();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pending_samples[0];
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_idle && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 19);
    end
  end

  // accept, predict, compare and watchdog
  always @(posedge clk_i) begin
    modulation_t got, want;
    bit          busy;
    busy = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      busy = 1'b1;
      void'(pending_samples.pop_front());
      expected_results.push_back(predict_modulation(s_axis_tdata, period_shadow));
      if (send_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      busy = 1'b1;
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("sector", 16'(want.sector), 16'(got.sector));
        check_field("duty_ticks", want.duty, got.duty);
        check_field("cmp_a1", want.cmp_a1, got.cmp_a1);
        check_field("cmp_b1", want.cmp_b1, got.cmp_b1);
        check_field("cmp_a2", want.cmp_a2, got.cmp_a2);
        check_field("cmp_b2", want.cmp_b2, got.cmp_b2);
        check_field("cmp_a3", want.cmp_a3, got.cmp_a3);
        check_field("cmp_b3", want.cmp_b3, got.cmp_b3);
        check_field("force_set_mask", 16'(want.mask), 16'(got.mask));
        check_field("padding", 16'(want.pad), 16'(got.pad));
      end
    end
    if (psel && penable && pready) busy = 1'b1;
    if (!rst_ni || busy) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // phase sequencing
  initial begin
    logic [rsdm_pkg::PERIOD_W-1:0] per;
    int ph, n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset value, then directed corners at the reset period
    reg_access(1'b0, ADDR_PERIOD, '0);
    push_sample(100, -30);
    push_sample(100, 30);
    push_sample(-30, 100);
    push_sample(-100, 30);
    push_sample(-30, -70);
    push_sample(30, -100);
    push_sample(0, 0);
    push_sample(5, -5);
    push_sample(-5, 5);
    push_sample(-32768, -32768);
    push_sample(32767, 32767);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(-32768, 0);
    push_sample(0, -32768);
    push_sample(32767, 0);
    push_sample(0, 32767);
    push_sample(-1, -1);
    push_sample(1, 1);
    push_sample(1, 0);
    push_sample(0, 1);
    push_sample(-1, 0);
    push_sample(0, -3);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: per = 16'd1;
        1: per = 16'd65534;
        2: per = 16'd0;
        3: per = 16'd65535;
        4: per = 16'd2;
        default: per = rsdm_pkg::PERIOD_W'($urandom_range(1, 65534));
      endcase
      if (ph == NUM_PHASES - 1) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if (ph > 1) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      reg_access(1'b1, ADDR_PERIOD, {16'($urandom), per});
      reg_access(1'b0, ADDR_PERIOD, '0);
      // a write to an unmapped index must leave the period alone
      if (ph == 5) begin
        reg_access(1'b1, ADDR_NO_REG, $urandom);
        reg_access(1'b0, ADDR_PERIOD, '0);
      end
      for (n = 0; n < PHASE_ITEMS; n++) pending_samples.push_back(random_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
